@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the list RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, checked on clk, quiet during rst
`define BLPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold, checked on clk, quiet during rst
`define BLPI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ rtl/core/blpi_pkg.sv @@
// Package: shared types and constants of the bounded list
`timescale 1ns / 1ps
package blpi_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 8;
  localparam int KIND_W       = 3;
  localparam int STAT_W       = 2;
  localparam int IN_DW        = 40;

  typedef enum logic [KIND_W-1:0] {
    K_ADD_FRONT = 3'd0,
    K_ADD_BACK  = 3'd1,
    K_INSERT    = 3'd2,
    K_REM_FRONT = 3'd3,
    K_REM_BACK  = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell: open a gap at the index, or close the gap there
  typedef struct packed {
    logic ins;
    logic rem;
  } cmd_t;

endpackage

@@ rtl/core/blpi_cell.sv @@
// One storage cell of the list row
`timescale 1ns / 1ps
module blpi_cell
  import blpi_pkg::*;
#(
  parameter int IDX = 0,
  parameter int AW  = 4
) (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [AW-1:0]    at,
  input  logic [VAL_W-1:0] val,
  input  logic [VAL_W-1:0] left_q,
  input  logic [VAL_W-1:0] right_q,
  output logic [VAL_W-1:0] q
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  // load at the gap, take the front neighbour behind it, or close a gap
  always_ff @(posedge clk) begin
    priority if (cmd.ins && at == MY_IDX) begin
      q <= val;
    end else if (cmd.ins && at < MY_IDX) begin
      q <= left_q;
    end else if (cmd.rem && at <= MY_IDX) begin
      q <= right_q;
    end else begin
      // hold
      q <= q;
    end
  end

endmodule

@@ rtl/core/blpi_outq.sv @@
// Two-slot output register with skid slot
`timescale 1ns / 1ps
module blpi_outq
  import blpi_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         push;
  logic         pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload moves with the valid bits above
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

endmodule

@@ rtl/core/bounded_list_with_positional_insert.sv @@
// Top level: bounded ordered list with front/back/positional add and remove
// The result of an item is registered in the output queue when the item is accepted.
// Throughput: one item per cycle while s_tready is high; cells load, shift or hold at once.
// A two-slot output queue keeps s_tready high while one result waits downstream.
// Reset (rst, synchronous): empties the list and the output queue; cell contents stay.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bounded_list_with_positional_insert
  import blpi_pkg::*;
#(
  parameter  int CAPACITY = CAPACITY_DEF,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int ODW      = ((VAL_W + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // position [7:0], value [39:8]
  input  logic [KIND_W-1:0] s_tuser,   // kind [2:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [ODW-1:0]    m_tdata,   // removed_value [31:0], length_after above, zero pad
  output logic [STAT_W-1:0] m_tuser    // status [1:0]
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int QW   = STAT_W + ODW;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [VAL_W-1:0] ent [CAPACITY];

  logic              accept;
  kind_t             kind;
  logic [POS_W-1:0]  pos;
  logic [VAL_W-1:0]  val;
  logic              full;
  logic              empty;
  cmd_t              cmd;
  logic [CW-1:0]     at_full;
  logic [AW-1:0]     at;
  logic [AW-1:0]     back_idx;
  logic [VAL_W-1:0]  removed;
  status_t           status;
  logic              q_ready;
  logic [QW-1:0]     q_out;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = q_ready;
  assign kind     = kind_t'(s_tuser);
  assign pos      = s_tdata[POS_W-1:0];
  assign val      = s_tdata[POS_W +: VAL_W];
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign back_idx = AW'(count - 1'b1);
  assign at       = at_full[AW-1:0];

  // Decode the item: where the gap opens or closes, and what the result says.
  // Dropped adds and removes from an empty list leave the row untouched.
  always_comb begin
    cmd        = '0;
    at_full    = '0;
    removed    = '0;
    status     = ST_OK;
    count_next = count;
    unique case (kind)
      K_ADD_FRONT, K_ADD_BACK, K_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + 1'b1;
          if (kind == K_ADD_FRONT) begin
            at_full = '0;
          end else if (kind == K_ADD_BACK ||
                       CMPW'(pos) >= CMPW'(count)) begin
            // append where the position reaches or passes the length
            at_full = count;
          end else begin
            at_full = CW'(pos);
          end
        end
      end
      K_REM_FRONT, K_REM_BACK: begin
        if (empty) begin
          status  = ST_EMPTY;
          removed = '1;
        end else begin
          cmd.rem    = 1'b1;
          count_next = count - 1'b1;
          if (kind == K_REM_FRONT) begin
            at_full = '0;
            removed = ent[0];
          end else begin
            at_full = CW'(back_idx);
            removed = ent[back_idx];
          end
        end
      end
      default: begin
        // unused kind codes: report the length, change nothing
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Cell 0 is the front. Its left input is val; the last cell's right input is its own q.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_q;
    logic [VAL_W-1:0] right_q;
    cmd_t             cell_cmd;

    if (i == 0) begin : g_first
      assign left_q = val;
    end else begin : g_mid_l
      assign left_q = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_q = ent[i];
    end else begin : g_mid_r
      assign right_q = ent[i+1];
    end

    // only an accepted item moves the row
    assign cell_cmd.ins = cmd.ins && accept;
    assign cell_cmd.rem = cmd.rem && accept;

    blpi_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk     (clk),
      .cmd     (cell_cmd),
      .at      (at),
      .val     (val),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (ent[i])
    );
  end

  // Result register with a skid slot behind it
  blpi_outq #(
    .W (QW)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (q_ready),
    .in_data   ({status, ODW'({count_next, removed})}),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_out)
  );

  assign m_tdata = q_out[ODW-1:0];
  assign m_tuser = q_out[QW-1 -: STAT_W];

  `BLPI_ASSERT_NEVER(a_count_in_range, count > CW'(CAPACITY), "length beyond capacity")
  `BLPI_ASSERT_NEXT(a_full_add_drops,
    accept && full && (s_tuser == K_ADD_FRONT || s_tuser == K_ADD_BACK ||
    s_tuser == K_INSERT), full, "add to a full list changed the length")
  `BLPI_ASSERT_NEXT(a_remove_shrinks,
    accept && !empty && (s_tuser == K_REM_FRONT || s_tuser == K_REM_BACK),
    count == $past(count) - 1'b1, "remove did not shrink the list by one")

endmodule
